// File: hw/rtl/avdp_pkg.sv
// ----------------------------------------------------------------------------
// avdp_pkg
// Shared widths, register codes, configuration record and helpers for the
// velocity predictor datapath.
// ----------------------------------------------------------------------------
package avdp_pkg;

	localparam int DATA_W         = 32;  // velocity words, signed fixed point
	localparam int CFG_W          = 32;  // coefficient registers, unsigned
	localparam int CFG_IDX_W      = 3;
	localparam int NUM_REGS       = 5;
	localparam int GUARD_W        = 48;  // saturation range of every product
	localparam int LAP_W          = 34;  // neighbour differences and laplacian sums
	localparam int DIFF_W         = GUARD_W + 2;
	localparam int E_W            = GUARD_W + 3;
	localparam int PIPE_DEPTH     = 14;
	localparam int FRAC_BITS_DEF  = 16;

	localparam logic [CFG_W-1:0] TIME_STEP_RST   = 32'd66;
	localparam logic [CFG_W-1:0] HALF_INV_DX_RST = 32'd65536;
	localparam logic [CFG_W-1:0] HALF_INV_DY_RST = 32'd65536;
	localparam logic [CFG_W-1:0] VISC_DX_RST     = 32'd65536;
	localparam logic [CFG_W-1:0] VISC_DY_RST     = 32'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIME_STEP   = 3'd0,
		REG_HALF_INV_DX = 3'd1,
		REG_HALF_INV_DY = 3'd2,
		REG_VISC_DX     = 3'd3,
		REG_VISC_DY     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] time_step;
		logic [CFG_W-1:0] half_inv_dx;
		logic [CFG_W-1:0] half_inv_dy;
		logic [CFG_W-1:0] visc_over_dx_sq;
		logic [CFG_W-1:0] visc_over_dy_sq;
	} cfg_regs_t;

	// sign and magnitude back to two's complement
	function automatic logic signed [GUARD_W:0] sm_to_s(input logic neg,
			input logic [GUARD_W-1:0] mag);
		logic signed [GUARD_W:0] m;
		m = $signed({1'b0, mag});
		return neg ? -m : m;
	endfunction

endpackage

// File: hw/rtl/avdp_mulq.sv
// ----------------------------------------------------------------------------
// avdp_mulq
// Three-stage sign-magnitude multiplier: split partial products, merge with
// round-half-away, then shift and saturate the magnitude to the guard range.
// ----------------------------------------------------------------------------
module avdp_mulq
	import avdp_pkg::*;
#(
	parameter int AW        = 34,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               a_neg,
	input  logic [AW-1:0]      a_mag,
	input  logic               c_neg,
	input  logic [CFG_W-1:0]   c,
	output logic               q_neg,
	output logic [GUARD_W-1:0] q_mag,
	output logic               sat
);

	localparam int LO_W = AW / 2;
	localparam int HI_W = AW - LO_W;
	localparam int PW   = AW + CFG_W + 1;
	localparam int QFW  = PW - FRAC_BITS;
	localparam int CW   = (QFW > GUARD_W) ? QFW : GUARD_W + 1;
	localparam logic [PW-1:0]      HALF    = PW'(1) << (FRAC_BITS - 1);
	localparam logic [CW-1:0]      LIM_NEG = CW'(1) << (GUARD_W - 1);
	localparam logic [CW-1:0]      LIM_POS = LIM_NEG - CW'(1);
	localparam logic [GUARD_W-1:0] MAG_POS = LIM_POS[GUARD_W-1:0];
	localparam logic [GUARD_W-1:0] MAG_NEG = LIM_NEG[GUARD_W-1:0];

	logic [LO_W+CFG_W-1:0] lo_s1;
	logic [HI_W+CFG_W-1:0] hi_s1;
	logic                  neg_s1;
	logic [PW-1:0]         full_s2;
	logic                  neg_s2;
	logic [GUARD_W-1:0]    q_s3;
	logic                  neg_s3;
	logic                  sat_s3;

	logic [CW-1:0] qx;
	logic [CW-1:0] lim;
	logic          ovf;

	always_comb begin
		qx  = CW'(full_s2 >> FRAC_BITS);
		lim = neg_s2 ? LIM_NEG : LIM_POS;
		ovf = qx > lim;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1   <= (LO_W+CFG_W)'(a_mag[LO_W-1:0]) * (LO_W+CFG_W)'(c);
			hi_s1   <= (HI_W+CFG_W)'(a_mag[AW-1:LO_W]) * (HI_W+CFG_W)'(c);
			neg_s1  <= a_neg ^ c_neg;
			full_s2 <= (PW'(hi_s1) << LO_W) + PW'(lo_s1) + HALF;
			neg_s2  <= neg_s1;
			q_s3    <= ovf ? lim[GUARD_W-1:0] : qx[GUARD_W-1:0];
			neg_s3  <= neg_s2;
			sat_s3  <= ovf;
		end
	end

	assign q_neg = neg_s3;
	assign q_mag = q_s3;
	assign sat   = sat_s3;

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		sat_s3 |-> (q_s3 == MAG_POS || q_s3 == MAG_NEG))
		else $error("saturated magnitude is not at a limit");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!neg_s3 |-> q_s3 <= MAG_POS)
		else $error("positive magnitude beyond guard range");

endmodule

// File: hw/rtl/avdp_cfg.sv
// ----------------------------------------------------------------------------
// avdp_cfg
// Coefficient register file: dt, gradient and viscosity scales.
// ----------------------------------------------------------------------------
module avdp_cfg
	import avdp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output cfg_regs_t            regs
);

	cfg_regs_t regs_q;
	cfg_reg_t  idx;

	assign idx      = cfg_reg_t'(wr_index);
	assign wr_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.time_step       <= TIME_STEP_RST;
			regs_q.half_inv_dx     <= HALF_INV_DX_RST;
			regs_q.half_inv_dy     <= HALF_INV_DY_RST;
			regs_q.visc_over_dx_sq <= VISC_DX_RST;
			regs_q.visc_over_dy_sq <= VISC_DY_RST;
		end else if (wr_valid && wr_ready) begin
			case (idx)
				REG_TIME_STEP:   regs_q.time_step       <= wr_data;
				REG_HALF_INV_DX: regs_q.half_inv_dx     <= wr_data;
				REG_HALF_INV_DY: regs_q.half_inv_dy     <= wr_data;
				REG_VISC_DX:     regs_q.visc_over_dx_sq <= wr_data;
				REG_VISC_DY:     regs_q.visc_over_dy_sq <= wr_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

	a_dt_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr_ready && idx == REG_TIME_STEP |=> regs_q.time_step == $past(wr_data))
		else $error("time step write lost");

	a_unknown_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr_ready && wr_index >= CFG_IDX_W'(NUM_REGS) |=> $stable(regs_q))
		else $error("write to unknown index changed a register");

endmodule

// File: hw/rtl/avdp_lane.sv
// ----------------------------------------------------------------------------
// avdp_lane
// One velocity component through the stencil: differences, gradient and
// laplacian products, convection products, Euler update and final clamp.
// ----------------------------------------------------------------------------
module avdp_lane
	import avdp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  cfg_regs_t                cfg,
	input  logic signed [DATA_W-1:0] mid,
	input  logic signed [DATA_W-1:0] west,
	input  logic signed [DATA_W-1:0] east,
	input  logic signed [DATA_W-1:0] south,
	input  logic signed [DATA_W-1:0] north,
	input  logic signed [DATA_W-1:0] um,
	input  logic signed [DATA_W-1:0] vm,
	output logic signed [DATA_W-1:0] pred,
	output logic                     clip
);

	localparam int SUM_W = GUARD_W + 2;
	localparam logic signed [SUM_W-1:0] OUT_MAX = (SUM_W'(1) <<< (DATA_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] OUT_MIN = -OUT_MAX - SUM_W'(1);

	// s1: differences and laplacian sums
	logic signed [LAP_W-1:0]  dx_s1, dy_s1, lx_s1, ly_s1;
	logic signed [DATA_W-1:0] um_s1, vm_s1;
	// s2: sign and magnitude
	logic                     dx_neg_s2, dy_neg_s2, lx_neg_s2, ly_neg_s2;
	logic [LAP_W-1:0]         dx_mag_s2, dy_mag_s2, lx_mag_s2, ly_mag_s2;
	logic                     um_neg_s2, vm_neg_s2, um_neg_s3, vm_neg_s3;
	logic                     um_neg_s4, vm_neg_s4, um_neg_s5, vm_neg_s5;
	logic [DATA_W-1:0]        um_mag_s2, vm_mag_s2, um_mag_s3, vm_mag_s3;
	logic [DATA_W-1:0]        um_mag_s4, vm_mag_s4, um_mag_s5, vm_mag_s5;
	// mid value travels alongside, entry k holds stage k+1
	logic signed [DATA_W-1:0] mid_s [PIPE_DEPTH-1];

	// first level products, out at s5
	logic                     gx_neg, gy_neg, lxx_neg, lyy_neg;
	logic [GUARD_W-1:0]       gx_mag, gy_mag, lxx_mag, lyy_mag;
	logic                     gx_sat, gy_sat, lxx_sat, lyy_sat;
	// convection products, out at s8
	logic                     cx_neg, cy_neg, cx_sat, cy_sat;
	logic [GUARD_W-1:0]       cx_mag, cy_mag;
	// dt product, out at s13
	logic                     upd_neg, upd_sat;
	logic [GUARD_W-1:0]       upd_mag;

	logic signed [DIFF_W-1:0] diff_s6, diff_s7, diff_s8;
	logic signed [E_W-1:0]    e_s9;
	logic                     e_neg_s10;
	logic [E_W-1:0]           e_mag_s10;
	logic                     clip_s6, clip_s7, clip_s8, clip_s9, clip_s10;
	logic                     clip_s11, clip_s12, clip_s13, clip_s14;
	logic signed [DATA_W-1:0] pred_s14;

	logic signed [SUM_W-1:0]  sum;
	logic                     final_sat;

	always_comb begin
		sum       = SUM_W'(mid_s[PIPE_DEPTH-2]) + SUM_W'(sm_to_s(upd_neg, upd_mag));
		final_sat = (sum > OUT_MAX) || (sum < OUT_MIN);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= LAP_W'(east) - LAP_W'(west);
			dy_s1 <= LAP_W'(north) - LAP_W'(south);
			lx_s1 <= LAP_W'(west) + LAP_W'(east) - (LAP_W'(mid) <<< 1);
			ly_s1 <= LAP_W'(south) + LAP_W'(north) - (LAP_W'(mid) <<< 1);
			um_s1 <= um;
			vm_s1 <= vm;

			dx_neg_s2 <= dx_s1[LAP_W-1];
			dx_mag_s2 <= dx_s1[LAP_W-1] ? LAP_W'(-dx_s1) : LAP_W'(dx_s1);
			dy_neg_s2 <= dy_s1[LAP_W-1];
			dy_mag_s2 <= dy_s1[LAP_W-1] ? LAP_W'(-dy_s1) : LAP_W'(dy_s1);
			lx_neg_s2 <= lx_s1[LAP_W-1];
			lx_mag_s2 <= lx_s1[LAP_W-1] ? LAP_W'(-lx_s1) : LAP_W'(lx_s1);
			ly_neg_s2 <= ly_s1[LAP_W-1];
			ly_mag_s2 <= ly_s1[LAP_W-1] ? LAP_W'(-ly_s1) : LAP_W'(ly_s1);
			um_neg_s2 <= um_s1[DATA_W-1];
			um_mag_s2 <= um_s1[DATA_W-1] ? DATA_W'(-um_s1) : DATA_W'(um_s1);
			vm_neg_s2 <= vm_s1[DATA_W-1];
			vm_mag_s2 <= vm_s1[DATA_W-1] ? DATA_W'(-vm_s1) : DATA_W'(vm_s1);

			um_neg_s3 <= um_neg_s2;
			um_mag_s3 <= um_mag_s2;
			vm_neg_s3 <= vm_neg_s2;
			vm_mag_s3 <= vm_mag_s2;
			um_neg_s4 <= um_neg_s3;
			um_mag_s4 <= um_mag_s3;
			vm_neg_s4 <= vm_neg_s3;
			vm_mag_s4 <= vm_mag_s3;
			um_neg_s5 <= um_neg_s4;
			um_mag_s5 <= um_mag_s4;
			vm_neg_s5 <= vm_neg_s4;
			vm_mag_s5 <= vm_mag_s4;

			mid_s[0] <= mid;
			for (int k = 1; k < PIPE_DEPTH - 1; k++) begin
				mid_s[k] <= mid_s[k-1];
			end

			diff_s6 <= DIFF_W'(sm_to_s(lxx_neg, lxx_mag)) + DIFF_W'(sm_to_s(lyy_neg, lyy_mag));
			clip_s6 <= gx_sat | gy_sat | lxx_sat | lyy_sat;
			diff_s7 <= diff_s6;
			clip_s7 <= clip_s6;
			diff_s8 <= diff_s7;
			clip_s8 <= clip_s7;

			// diffusion minus convection
			e_s9    <= E_W'(diff_s8) - E_W'(sm_to_s(cx_neg, cx_mag))
				- E_W'(sm_to_s(cy_neg, cy_mag));
			clip_s9 <= clip_s8 | cx_sat | cy_sat;

			e_neg_s10 <= e_s9[E_W-1];
			e_mag_s10 <= e_s9[E_W-1] ? E_W'(-e_s9) : E_W'(e_s9);
			clip_s10  <= clip_s9;
			clip_s11  <= clip_s10;
			clip_s12  <= clip_s11;
			clip_s13  <= clip_s12;

			if (final_sat) begin
				pred_s14 <= (sum > OUT_MAX) ? OUT_MAX[DATA_W-1:0] : OUT_MIN[DATA_W-1:0];
			end else begin
				pred_s14 <= sum[DATA_W-1:0];
			end
			clip_s14 <= clip_s13 | upd_sat | final_sat;
		end
	end

	avdp_mulq #(.AW(LAP_W), .FRAC_BITS(FRAC_BITS)) u_gx (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a_neg(dx_neg_s2), .a_mag(dx_mag_s2), .c_neg(1'b0), .c(cfg.half_inv_dx),
		.q_neg(gx_neg), .q_mag(gx_mag), .sat(gx_sat)
	);

	avdp_mulq #(.AW(LAP_W), .FRAC_BITS(FRAC_BITS)) u_gy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a_neg(dy_neg_s2), .a_mag(dy_mag_s2), .c_neg(1'b0), .c(cfg.half_inv_dy),
		.q_neg(gy_neg), .q_mag(gy_mag), .sat(gy_sat)
	);

	avdp_mulq #(.AW(LAP_W), .FRAC_BITS(FRAC_BITS)) u_lxx (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a_neg(lx_neg_s2), .a_mag(lx_mag_s2), .c_neg(1'b0), .c(cfg.visc_over_dx_sq),
		.q_neg(lxx_neg), .q_mag(lxx_mag), .sat(lxx_sat)
	);

	avdp_mulq #(.AW(LAP_W), .FRAC_BITS(FRAC_BITS)) u_lyy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a_neg(ly_neg_s2), .a_mag(ly_mag_s2), .c_neg(1'b0), .c(cfg.visc_over_dy_sq),
		.q_neg(lyy_neg), .q_mag(lyy_mag), .sat(lyy_sat)
	);

	avdp_mulq #(.AW(GUARD_W), .FRAC_BITS(FRAC_BITS)) u_cx (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a_neg(gx_neg), .a_mag(gx_mag), .c_neg(um_neg_s5), .c(um_mag_s5),
		.q_neg(cx_neg), .q_mag(cx_mag), .sat(cx_sat)
	);

	avdp_mulq #(.AW(GUARD_W), .FRAC_BITS(FRAC_BITS)) u_cy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a_neg(gy_neg), .a_mag(gy_mag), .c_neg(vm_neg_s5), .c(vm_mag_s5),
		.q_neg(cy_neg), .q_mag(cy_mag), .sat(cy_sat)
	);

	avdp_mulq #(.AW(E_W), .FRAC_BITS(FRAC_BITS)) u_dt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a_neg(e_neg_s10), .a_mag(e_mag_s10), .c_neg(1'b0), .c(cfg.time_step),
		.q_neg(upd_neg), .q_mag(upd_mag), .sat(upd_sat)
	);

	assign pred = pred_s14;
	assign clip = clip_s14;

endmodule

// File: hw/rtl/advection_diffusion_velocity_predict.sv
// ----------------------------------------------------------------------------
// advection_diffusion_velocity_predict
// Explicit Euler velocity predictor for one interior cell of a 2-D grid.
//
// Input channel (in_valid / in_stall): the five-point neighbourhoods of u and
// v for one cell, signed fixed point. Output channel (out_valid / out_stall):
// the predicted u and v, clamped to 32 bits, with clipped set when any
// product or the final sum saturated. Configuration channel (cfg_valid /
// cfg_ready, always ready): cfg_index 0..4 selects dt, 1/(2dx), 1/(2dy),
// nu/dx^2, nu/dy^2; other indexes are dropped. Write only while idle.
//
// The pipeline is 14 register stages deep; out_valid is the valid bit of
// the last stage. One cell enters every cycle while the output is not
// stalled. Each component runs its own lane of seven three-stage
// multipliers in three dependent levels (gradient and laplacian, convection,
// dt), which sets the depth. When the receiver stalls with a result held,
// the whole pipeline freezes and in_stall rises in the same cycle; bubbles
// keep moving otherwise. Reset empties the pipeline and loads the default
// coefficients.
// ----------------------------------------------------------------------------
module advection_diffusion_velocity_predict
	import avdp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] u_mid,
	input  logic signed [DATA_W-1:0] u_west,
	input  logic signed [DATA_W-1:0] u_east,
	input  logic signed [DATA_W-1:0] u_south,
	input  logic signed [DATA_W-1:0] u_north,
	input  logic signed [DATA_W-1:0] v_mid,
	input  logic signed [DATA_W-1:0] v_west,
	input  logic signed [DATA_W-1:0] v_east,
	input  logic signed [DATA_W-1:0] v_south,
	input  logic signed [DATA_W-1:0] v_north,

	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] u_pred,
	output logic signed [DATA_W-1:0] v_pred,
	output logic                     clipped,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	cfg_regs_t               cfg;
	logic [PIPE_DEPTH-1:0]   vld_s;
	logic                    adv;
	logic                    u_clip, v_clip;

	// everything moves unless a finished result waits on the receiver
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_DEPTH-2:0], in_valid};
		end
	end

	assign out_valid = vld_s[PIPE_DEPTH-1];
	assign clipped   = u_clip | v_clip;

	avdp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_ready (cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (cfg)
	);

	avdp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_u (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.cfg    (cfg),
		.mid    (u_mid),
		.west   (u_west),
		.east   (u_east),
		.south  (u_south),
		.north  (u_north),
		.um     (u_mid),
		.vm     (v_mid),
		.pred   (u_pred),
		.clip   (u_clip)
	);

	avdp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_v (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.cfg    (cfg),
		.mid    (v_mid),
		.west   (v_west),
		.east   (v_east),
		.south  (v_south),
		.north  (v_north),
		.um     (u_mid),
		.vm     (v_mid),
		.pred   (v_pred),
		.clip   (v_clip)
	);

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline valid bits moved during a stall");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> vld_s[0] == $past(in_valid))
		else $error("input transfer not captured in the first stage");

endmodule

// File: dv/advection_diffusion_velocity_predict_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// advection_diffusion_velocity_predict_tb
// Self-checking bench for the explicit Euler velocity predictor. Cells are
// streamed through the input channel under random gaps and output stalls.
// An in-bench fixed-point predictor computes u_pred, v_pred and clipped for
// every transfer, and each result is checked in order. Coefficients are
// reprogrammed between drained phases, covering zero, full-scale and typical
// values.
// ----------------------------------------------------------------------------
module advection_diffusion_velocity_predict_tb
	import avdp_pkg::*;
();

	localparam int CLK_HALF       = 10;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int FRAC           = FRAC_BITS_DEF;
	localparam int HOLD_CYCLES    = 60;
	localparam int RECONFIG_EVERY = 45;

	localparam logic signed [DATA_W-1:0] VEL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] VEL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VEL_ONE = 1 << FRAC;
	localparam logic [CFG_W-1:0]         COEFF_MAX  = '1;
	localparam logic [CFG_W-1:0]         COEFF_HALF = 1 << (FRAC - 1);
	localparam logic [CFG_W-1:0]         COEFF_ONE  = 1 << FRAC;
	localparam logic [CFG_IDX_W-1:0]     STRAY_IDX_LOW  = CFG_IDX_W'(NUM_REGS);
	localparam logic [CFG_IDX_W-1:0]     STRAY_IDX_HIGH = '1;
	localparam longint WORD_HI = (longint'(1) <<< (DATA_W - 1)) - 1;
	localparam longint WORD_LO = -WORD_HI - 1;

	typedef struct packed {
		logic signed [DATA_W-1:0] mid;
		logic signed [DATA_W-1:0] west;
		logic signed [DATA_W-1:0] east;
		logic signed [DATA_W-1:0] south;
		logic signed [DATA_W-1:0] north;
	} nbhd_t;

	typedef struct packed {
		nbhd_t u;
		nbhd_t v;
	} cell_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] u_pred;
		logic signed [DATA_W-1:0] v_pred;
		logic                     clipped;
	} prediction_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [DATA_W-1:0] u_mid, u_west, u_east, u_south, u_north;
	logic signed [DATA_W-1:0] v_mid, v_west, v_east, v_south, v_north;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] u_pred;
	logic signed [DATA_W-1:0] v_pred;
	logic                     clipped;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]         cfg_data;

	cfg_regs_t   coeffs;
	logic        stage_clipped;
	prediction_t pending_predictions[$];
	int          send_gap_pct;
	int          stall_pct;
	bit          hold_request;
	int          fail_count;
	int          cells_sent;
	int          results_checked;
	int          clipped_results;
	int          settings_written;

	advection_diffusion_velocity_predict #(
		.FRAC_BITS(FRAC)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.u_mid    (u_mid),
		.u_west   (u_west),
		.u_east   (u_east),
		.u_south  (u_south),
		.u_north  (u_north),
		.v_mid    (v_mid),
		.v_west   (v_west),
		.v_east   (v_east),
		.v_south  (v_south),
		.v_north  (v_north),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.u_pred   (u_pred),
		.v_pred   (v_pred),
		.clipped  (clipped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// fixed-point predictor
	// ------------------------------------------------------------------
	function automatic longint wide(input logic signed [DATA_W-1:0] x);
		return longint'(x);
	endfunction

	// rounded product a * (+/-)c >> FRAC, ties away from zero, clamped to guard range
	function automatic longint scaled_product(input longint a, input bit c_neg,
			input longint unsigned c);
		bit           neg;
		logic [127:0] mag;
		logic [127:0] prod;
		logic [127:0] lim;
		neg  = (a < 0) != c_neg;
		mag  = (a < 0) ? 128'(-a) : 128'(a);
		prod = mag * c;
		prod = (prod + (128'd1 << (FRAC - 1))) >> FRAC;
		lim  = (128'd1 << (GUARD_W - 1)) - (neg ? 128'd0 : 128'd1);
		if (prod > lim) begin
			stage_clipped = 1'b1;
			prod = lim;
		end
		return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	function automatic logic signed [DATA_W-1:0] predict_component(input nbhd_t n,
			input longint um, input longint vm);
		longint mid, gx, gy, conv, lap, total;
		mid  = wide(n.mid);
		gx   = scaled_product(wide(n.east) - wide(n.west), 1'b0, coeffs.half_inv_dx);
		gy   = scaled_product(wide(n.north) - wide(n.south), 1'b0, coeffs.half_inv_dy);
		conv = scaled_product(gx, um < 0, (um < 0) ? -um : um)
		     + scaled_product(gy, vm < 0, (vm < 0) ? -vm : vm);
		lap  = scaled_product(wide(n.west) + wide(n.east) - 2 * mid, 1'b0,
				coeffs.visc_over_dx_sq)
		     + scaled_product(wide(n.south) + wide(n.north) - 2 * mid, 1'b0,
				coeffs.visc_over_dy_sq);
		total = mid + scaled_product(lap - conv, 1'b0, coeffs.time_step);
		if (total > WORD_HI) begin
			stage_clipped = 1'b1;
			total = WORD_HI;
		end else if (total < WORD_LO) begin
			stage_clipped = 1'b1;
			total = WORD_LO;
		end
		return total[DATA_W-1:0];
	endfunction

	function automatic prediction_t predict_cell(input cell_t c);
		prediction_t p;
		stage_clipped = 1'b0;
		p.u_pred  = predict_component(c.u, wide(c.u.mid), wide(c.v.mid));
		p.v_pred  = predict_component(c.v, wide(c.u.mid), wide(c.v.mid));
		p.clipped = stage_clipped;
		return p;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic nbhd_t nbhd(input logic signed [DATA_W-1:0] mid, west, east,
			south, north);
		return {mid, west, east, south, north};
	endfunction

	// random word with a random magnitude, so small and large values both show up
	function automatic logic signed [DATA_W-1:0] spread_word();
		logic signed [DATA_W-1:0] w;
		w = $urandom();
		return w >>> $urandom_range(DATA_W - 1);
	endfunction

	function automatic logic signed [DATA_W-1:0] extreme_word();
		case ($urandom_range(5))
			0: return VEL_MIN;
			1: return VEL_MAX;
			2: return '0;
			3: return -1;
			4: return VEL_ONE;
			default: return $urandom();
		endcase
	endfunction

	// neighbours close to the center value, like a resolved flow field
	function automatic nbhd_t smooth_nbhd();
		logic signed [DATA_W-1:0] base;
		logic signed [DATA_W-1:0] jit [4];
		int unsigned sh;
		base = spread_word();
		sh = $urandom_range(DATA_W - 1, 8);
		for (int k = 0; k < 4; k++)
			jit[k] = $signed($urandom()) >>> sh;
		return nbhd(base, base + jit[0], base + jit[1], base + jit[2], base + jit[3]);
	endfunction

	function automatic cell_t random_cell();
		int unsigned kind;
		kind = $urandom_range(9);
		if (kind < 5)
			return {smooth_nbhd(), smooth_nbhd()};
		else if (kind < 8)
			return {nbhd(spread_word(), spread_word(), spread_word(), spread_word(),
					spread_word()),
				nbhd(spread_word(), spread_word(), spread_word(), spread_word(),
					spread_word())};
		else if (kind == 8)
			return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		else
			return {nbhd(extreme_word(), extreme_word(), extreme_word(), extreme_word(),
					extreme_word()),
				nbhd(extreme_word(), extreme_word(), extreme_word(), extreme_word(),
					extreme_word())};
	endfunction

	// mostly physical coefficients, one time in four a full-range word
	function automatic cfg_regs_t random_coeffs();
		cfg_regs_t c;
		c.time_step       = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(4096);
		c.half_inv_dx     = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1 << 22);
		c.half_inv_dy     = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1 << 22);
		c.visc_over_dx_sq = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1 << 20);
		c.visc_over_dy_sq = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1 << 20);
		return c;
	endfunction

	task automatic set_traffic(input int gap_pct, input int stall_in_pct);
		send_gap_pct = gap_pct;
		stall_pct = stall_in_pct;
	endtask

	// leaves cfg_valid high so that back-to-back writes need no gap
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(negedge clk); while (cfg_ready !== 1'b1);
		@(posedge clk);
		case (idx)
			REG_TIME_STEP:   coeffs.time_step       = data;
			REG_HALF_INV_DX: coeffs.half_inv_dx     = data;
			REG_HALF_INV_DY: coeffs.half_inv_dy     = data;
			REG_VISC_DX:     coeffs.visc_over_dx_sq = data;
			REG_VISC_DY:     coeffs.visc_over_dy_sq = data;
			default: ;  // unmapped index, block drops it
		endcase
	endtask

	// only called with the pipeline drained
	task automatic program_coeffs(input cfg_regs_t c, input bit stray);
		write_reg(REG_TIME_STEP, c.time_step);
		if (stray)
			write_reg(STRAY_IDX_LOW, $urandom());
		write_reg(REG_HALF_INV_DX, c.half_inv_dx);
		write_reg(REG_HALF_INV_DY, c.half_inv_dy);
		write_reg(REG_VISC_DX, c.visc_over_dx_sq);
		write_reg(REG_VISC_DY, c.visc_over_dy_sq);
		if (stray)
			write_reg(STRAY_IDX_HIGH, $urandom());
		cfg_valid <= 1'b0;
		settings_written++;
	endtask

	// valid stays high after the transfer, the caller drops it when done
	task automatic send_cell(input cell_t c);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		u_mid    <= c.u.mid;
		u_west   <= c.u.west;
		u_east   <= c.u.east;
		u_south  <= c.u.south;
		u_north  <= c.u.north;
		v_mid    <= c.v.mid;
		v_west   <= c.v.west;
		v_east   <= c.v.east;
		v_south  <= c.v.south;
		v_north  <= c.v.north;
		do @(negedge clk); while (in_stall !== 1'b0);
		pending_predictions.push_back(predict_cell(c));
		cells_sent++;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_predictions.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		set_traffic(24, 76);
		// default coefficients
		send_cell({nbhd('0, '0, '0, '0, '0), nbhd('0, '0, '0, '0, '0)});
		send_cell({nbhd(VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX),
			nbhd(VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX)});
		send_cell({nbhd(VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN),
			nbhd(VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN)});
		send_cell({nbhd('0, VEL_MIN, VEL_MAX, VEL_MIN, VEL_MAX),
			nbhd('0, VEL_MAX, VEL_MIN, VEL_MAX, VEL_MIN)});
		send_cell({nbhd(VEL_MAX, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN),
			nbhd(VEL_MIN, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX)});
		send_cell({nbhd(VEL_MIN, VEL_MIN, VEL_MAX, VEL_MAX, VEL_MIN),
			nbhd(VEL_MIN, VEL_MAX, VEL_MIN, VEL_MIN, VEL_MAX)});
		send_cell({nbhd(VEL_ONE, VEL_ONE >>> 1, 2 * VEL_ONE, -VEL_ONE, 3 * VEL_ONE),
			nbhd(-VEL_ONE, '0, -2 * VEL_ONE, VEL_ONE, -VEL_ONE >>> 2)});
		wait_idle();

		// full-scale coefficients, final sum clamps both ways
		program_coeffs({COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX}, 1'b0);
		send_cell({nbhd(VEL_MIN, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX),
			nbhd(VEL_MAX, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN)});
		send_cell({nbhd(VEL_ONE, '0, 2 * VEL_ONE, '0, VEL_ONE),
			nbhd(1, '0, -1, 1, '0)});
		wait_idle();

		// products saturate but dt = 0 keeps the sum in range
		program_coeffs({32'd0, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX}, 1'b0);
		send_cell({nbhd(VEL_ONE, VEL_MIN, VEL_MAX, VEL_MIN, VEL_MAX),
			nbhd(-VEL_ONE, VEL_MAX, VEL_MIN, VEL_MAX, VEL_MIN)});
		send_cell({nbhd('0, '0, '0, '0, '0), nbhd('0, '0, '0, '0, '0)});
		wait_idle();

		// half-unit coefficients land exactly on rounding ties; writes to
		// unmapped indexes in between must not disturb the registers
		program_coeffs({COEFF_ONE, COEFF_HALF, COEFF_HALF, COEFF_HALF, COEFF_HALF}, 1'b1);
		send_cell({nbhd('0, '0, 1, '0, '0), nbhd('0, '0, '0, '0, '0)});
		send_cell({nbhd('0, '0, -1, '0, '0), nbhd('0, '0, '0, -1, '0)});
		send_cell({nbhd(VEL_ONE, VEL_ONE + 1, VEL_ONE, VEL_ONE, VEL_ONE - 1),
			nbhd(-VEL_ONE, -VEL_ONE, -VEL_ONE - 1, -VEL_ONE + 1, -VEL_ONE)});
		send_cell({nbhd(-1, 1, '0, -1, '0), nbhd(1, '0, '0, '0, 1)});
		wait_idle();
	endtask

	task automatic test_coeff_sweep();
		cfg_regs_t settings [6];
		settings[0] = '0;
		settings[1] = {COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX};
		settings[2] = {TIME_STEP_RST, HALF_INV_DX_RST, HALF_INV_DY_RST, VISC_DX_RST,
			VISC_DY_RST};
		settings[3] = {32'd655, 32'd327680, 32'd163840, 32'd6554, 32'd3277};
		settings[4] = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		settings[5] = {COEFF_MAX, 32'd1, 32'd0, 32'd1, COEFF_MAX};
		set_traffic(24, 76);
		foreach (settings[s]) begin
			program_coeffs(settings[s], s == 4);
			repeat (12) send_cell(random_cell());
			wait_idle();
		end
	endtask

	task automatic test_random_traffic(input int gap_pct, input int stall_in_pct,
			input int count);
		set_traffic(gap_pct, stall_in_pct);
		for (int k = 0; k < count; k++) begin
			if (k % RECONFIG_EVERY == 0) begin
				wait_idle();
				program_coeffs(random_coeffs(), $urandom_range(3) == 0);
			end
			send_cell(random_cell());
		end
		wait_idle();
	endtask

	// receiver holds off long enough for the pipeline to fill and stall the input
	task automatic test_backpressure();
		set_traffic(0, 0);
		hold_request = 1'b1;
		repeat (40) send_cell(random_cell());
		wait_idle();
	endtask

	task automatic test_drain_pause();
		set_traffic(0, 30);
		repeat (10) send_cell(random_cell());
		wait_idle();
		repeat (10) send_cell(random_cell());
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// receiver stall
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// result checker, decides at the falling edge what transfers next rise
	// ------------------------------------------------------------------
	initial begin
		prediction_t want;
		forever begin
			@(negedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (pending_predictions.size() == 0) begin
					$error("prediction with no cell in flight: u_pred %0d v_pred %0d",
						u_pred, v_pred);
					fail_count++;
				end else begin
					want = pending_predictions.pop_front();
					results_checked++;
					if (want.clipped)
						clipped_results++;
					if (u_pred !== want.u_pred) begin
						$error("u_pred: expected %0d, got %0d", want.u_pred, u_pred);
						fail_count++;
					end
					if (v_pred !== want.v_pred) begin
						$error("v_pred: expected %0d, got %0d", want.v_pred, v_pred);
						fail_count++;
					end
					if (clipped !== want.clipped) begin
						$error("clipped: expected %0d, got %0d", want.clipped, clipped);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		u_mid     = '0;
		u_west    = '0;
		u_east    = '0;
		u_south   = '0;
		u_north   = '0;
		v_mid     = '0;
		v_west    = '0;
		v_east    = '0;
		v_south   = '0;
		v_north   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		hold_request     = 1'b0;
		send_gap_pct     = 0;
		stall_pct        = 0;
		fail_count       = 0;
		cells_sent       = 0;
		results_checked  = 0;
		clipped_results  = 0;
		settings_written = 0;
		coeffs = {TIME_STEP_RST, HALF_INV_DX_RST, HALF_INV_DY_RST, VISC_DX_RST, VISC_DY_RST};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_coeff_sweep();
		test_random_traffic(24, 76, 130);
		test_random_traffic(76, 24, 130);
		test_random_traffic(0, 0, 130);
		test_backpressure();
		test_drain_pause();
		wait_idle();

		$display("%0d cells streamed, %0d predictions checked, %0d of them clipped",
			cells_sent, results_checked, clipped_results);
		$display("%0d coefficient sets incl. zero and full scale, long output hold, drains",
			settings_written);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/avdp_pkg.sv
hw/rtl/avdp_mulq.sv
hw/rtl/avdp_cfg.sv
hw/rtl/avdp_lane.sv
hw/rtl/advection_diffusion_velocity_predict.sv
dv/advection_diffusion_velocity_predict_tb.sv
